// ----- sv/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define YFU_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define YFU_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/yfu_pkg.sv -----
// types, constants and address tables of the yee field update block
package yfu_pkg;

   localparam int VAL_W       = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int AXIS_W      = 4;
   localparam int CELL_AW     = 3 * AXIS_W;
   localparam int COMP_W      = 3;
   localparam int SEL_W       = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int NUM_FIELDS  = 6;
   localparam int NUM_COEFS   = 18;
   localparam int NUM_SELECTS = NUM_FIELDS + NUM_COEFS;
   localparam int FLD_AW      = COMP_W + CELL_AW;
   localparam int FLD_DEPTH   = NUM_FIELDS * (1 << CELL_AW);
   localparam int COEF_AW     = SEL_W + CELL_AW;
   localparam int COEF_DEPTH  = NUM_COEFS * (1 << CELL_AW);

   typedef logic [AXIS_W-1:0]       yfu_axis_type;
   typedef logic signed [VAL_W-1:0] yfu_val_type;

   localparam yfu_val_type VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam yfu_val_type VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] EXT_MAX = {{(PROD_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] EXT_MIN = {{(PROD_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

   typedef enum logic [1:0] {REQ_WRITE, REQ_READ, REQ_STEP, REQ_NOP} yfu_req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {CSR_NX, CSR_NY, CSR_NZ} yfu_csr_idx_type;

   typedef enum logic [COMP_W-1:0] {
      COMP_EX, COMP_EY, COMP_EZ, COMP_HX, COMP_HY, COMP_HZ
   } yfu_comp_type;

   // one sweep over one field component
   typedef enum logic [2:0] {
      JOB_EX1D, JOB_EX, JOB_EY, JOB_EZ, JOB_HX, JOB_HY, JOB_HZ
   } yfu_job_type;

   // operand fetch slots of one cell update
   typedef enum logic [2:0] {SLOT_OWN, SLOT_A1, SLOT_B1, SLOT_A2, SLOT_B2} yfu_slot_type;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_STEP} yfu_state_type;

   typedef enum logic [1:0] {SQ_IDLE, SQ_LOAD, SQ_RUN, SQ_DRAIN} yfu_seq_state_type;

   typedef struct packed {
      logic              valid;
      yfu_slot_type      slot;
      logic              single;
      logic [FLD_AW-1:0] own_addr;
   } yfu_op_type;

   typedef struct packed {
      logic              valid;
      logic [FLD_AW-1:0] addr;
      yfu_val_type       data;
   } yfu_wr_type;

   typedef struct packed {
      yfu_val_type value;
      logic        hit;
   } yfu_sat_type;

   // clamp a wide signed value into the value range
   function automatic yfu_sat_type clamp_val(input logic signed [PROD_W-1:0] x);
      yfu_sat_type r;
      if (x > EXT_MAX) begin
         r.value = VAL_MAX;
         r.hit   = 1'b1;
      end else if (x < EXT_MIN) begin
         r.value = VAL_MIN;
         r.hit   = 1'b1;
      end else begin
         r.value = x[VAL_W-1:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

   // lower loop bound per axis as {i, j, k}
   function automatic logic [2:0] job_low(input yfu_job_type job);
      logic [2:0] r;
      case (job) inside
         JOB_EX1D: r = 3'b001;
         JOB_EX:   r = 3'b011;
         JOB_EY:   r = 3'b101;
         JOB_EZ:   r = 3'b110;
         default:  r = 3'b000;
      endcase
      return r;
   endfunction

   function automatic yfu_job_type next_job(input yfu_job_type job);
      yfu_job_type r;
      case (job)
         JOB_EX:  r = JOB_EY;
         JOB_EY:  r = JOB_EZ;
         JOB_HX:  r = JOB_HY;
         JOB_HY:  r = JOB_HZ;
         default: r = JOB_HX;
      endcase
      return r;
   endfunction

   // field memory address of one operand
   function automatic logic [FLD_AW-1:0] fld_addr_of(input yfu_job_type job,
         input yfu_slot_type slot, input yfu_axis_type i, input yfu_axis_type j,
         input yfu_axis_type k);
      yfu_comp_type own, c1, c2;
      yfu_axis_type x, y, z;
      logic [1:0]   nb1, nb2;
      logic         dn;
      x   = i;
      y   = j;
      z   = k;
      own = COMP_EX;
      c1  = COMP_HY;
      c2  = COMP_HZ;
      // neighbor axis of each difference: 0 x, 1 y, 2 z
      nb1 = 2'd2;
      nb2 = 2'd1;
      dn  = 1'b1;
      case (job) inside
         JOB_EX1D, JOB_EX: begin
            own = COMP_EX; c1 = COMP_HY; nb1 = 2'd2; c2 = COMP_HZ; nb2 = 2'd1; dn = 1'b1;
         end
         JOB_EY: begin
            own = COMP_EY; c1 = COMP_HX; nb1 = 2'd2; c2 = COMP_HZ; nb2 = 2'd0; dn = 1'b1;
         end
         JOB_EZ: begin
            own = COMP_EZ; c1 = COMP_HX; nb1 = 2'd1; c2 = COMP_HY; nb2 = 2'd0; dn = 1'b1;
         end
         JOB_HX: begin
            own = COMP_HX; c1 = COMP_EY; nb1 = 2'd2; c2 = COMP_EZ; nb2 = 2'd1; dn = 1'b0;
         end
         JOB_HY: begin
            own = COMP_HY; c1 = COMP_EZ; nb1 = 2'd0; c2 = COMP_EX; nb2 = 2'd2; dn = 1'b0;
         end
         default: begin
            own = COMP_HZ; c1 = COMP_EX; nb1 = 2'd1; c2 = COMP_EY; nb2 = 2'd0; dn = 1'b0;
         end
      endcase
      // e updates use the cell below, h updates the cell above
      case (slot)
         SLOT_OWN: return {own, x, y, z};
         SLOT_A1:  return dn ? {c1, x, y, z} : shifted(c1, nb1, x, y, z);
         SLOT_B1:  return dn ? shifted_dn(c1, nb1, x, y, z) : {c1, x, y, z};
         SLOT_A2:  return dn ? {c2, x, y, z} : shifted(c2, nb2, x, y, z);
         default:  return dn ? shifted_dn(c2, nb2, x, y, z) : {c2, x, y, z};
      endcase
   endfunction

   function automatic logic [FLD_AW-1:0] shifted(input yfu_comp_type c, input logic [1:0] ax,
         input yfu_axis_type x, input yfu_axis_type y, input yfu_axis_type z);
      yfu_axis_type one;
      one = yfu_axis_type'(1);
      case (ax)
         2'd0:    return {c, x + one, y, z};
         2'd1:    return {c, x, y + one, z};
         default: return {c, x, y, z + one};
      endcase
   endfunction

   function automatic logic [FLD_AW-1:0] shifted_dn(input yfu_comp_type c,
         input logic [1:0] ax, input yfu_axis_type x, input yfu_axis_type y,
         input yfu_axis_type z);
      yfu_axis_type one;
      one = yfu_axis_type'(1);
      case (ax)
         2'd0:    return {c, x - one, y, z};
         2'd1:    return {c, x, y - one, z};
         default: return {c, x, y, z - one};
      endcase
   endfunction

   // coefficient array fetched with each slot: own term, first and second difference
   function automatic logic [SEL_W-1:0] coef_sel_of(input yfu_job_type job,
         input yfu_slot_type slot);
      logic [SEL_W-1:0] s0, s1, s2;
      case (job) inside
         JOB_EX1D, JOB_EX: begin s0 = 5'd9;  s1 = 5'd10; s2 = 5'd11; end
         JOB_EY:           begin s0 = 5'd12; s1 = 5'd14; s2 = 5'd13; end
         JOB_EZ:           begin s0 = 5'd15; s1 = 5'd16; s2 = 5'd17; end
         JOB_HX:           begin s0 = 5'd0;  s1 = 5'd1;  s2 = 5'd2;  end
         JOB_HY:           begin s0 = 5'd3;  s1 = 5'd4;  s2 = 5'd5;  end
         default:          begin s0 = 5'd6;  s1 = 5'd7;  s2 = 5'd8;  end
      endcase
      case (slot)
         SLOT_OWN: return s0;
         SLOT_A1:  return s1;
         default:  return s2;
      endcase
   endfunction

endpackage

// ----- sv/yfu_ifs.sv -----
// request, response and register write channels
interface yfu_req_if;
   import yfu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             req_type;
   logic [SEL_W-1:0]       array_select;
   logic [AXIS_W-1:0]      cell_x;
   logic [AXIS_W-1:0]      cell_y;
   logic [AXIS_W-1:0]      cell_z;
   logic signed [VAL_W-1:0] write_value;
   modport source (output valid, req_type, array_select, cell_x, cell_y, cell_z, write_value,
                   input ready);
   modport sink (input valid, req_type, array_select, cell_x, cell_y, cell_z, write_value,
                 output ready);
endinterface

interface yfu_rsp_if;
   import yfu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] read_value;
   logic                    step_done;
   logic                    saturated;
   modport source (output valid, read_value, step_done, saturated, input ready);
   modport sink (input valid, read_value, step_done, saturated, output ready);
endinterface

interface yfu_csr_if;
   import yfu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [AXIS_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/yfu_ram.sv -----
// generic simple dual port ram with registered read
module yfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/yfu_seq.sv -----
// sweep sequencer: walks component jobs and cells, issues operand reads
module yfu_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  yfu_pkg::yfu_axis_type        nx,
   input  yfu_pkg::yfu_axis_type        ny,
   input  yfu_pkg::yfu_axis_type        nz,
   input  logic                         dp_busy,
   output yfu_pkg::yfu_op_type          op,
   output logic [yfu_pkg::FLD_AW-1:0]   rd_fld_addr,
   output logic [yfu_pkg::COEF_AW-1:0]  rd_coef_addr,
   output logic                         done
);
   import yfu_pkg::*;

   yfu_seq_state_type state_ff, state_in;
   yfu_job_type       job_ff, job_in, job_nxt;
   yfu_slot_type      slot_ff, slot_in;
   yfu_axis_type      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   yfu_axis_type      lo_i, lo_j, lo_k;
   logic [2:0]        low;
   logic [AXIS_W:0]   i_nxt, j_nxt, k_nxt;
   logic              i_last, j_last, k_last, empty, to_drain;

   // loop bounds of the current job
   always_comb begin
      low      = job_low(job_ff);
      lo_i     = {{(AXIS_W-1){1'b0}}, low[2]};
      lo_j     = {{(AXIS_W-1){1'b0}}, low[1]};
      lo_k     = {{(AXIS_W-1){1'b0}}, low[0]};
      empty    = (nx <= lo_i) || (ny <= lo_j) || (nz <= lo_k);
      i_nxt    = {1'b0, i_ff} + {{AXIS_W{1'b0}}, 1'b1};
      j_nxt    = {1'b0, j_ff} + {{AXIS_W{1'b0}}, 1'b1};
      k_nxt    = {1'b0, k_ff} + {{AXIS_W{1'b0}}, 1'b1};
      i_last   = i_nxt >= {1'b0, nx};
      j_last   = j_nxt >= {1'b0, ny};
      k_last   = k_nxt >= {1'b0, nz};
      job_nxt  = next_job(job_ff);
      to_drain = (job_ff == JOB_HZ) || (job_nxt == JOB_HX);
   end

   // read addresses and operation tag
   always_comb begin
      op.valid     = (state_ff == SQ_RUN);
      op.slot      = slot_ff;
      op.single    = (job_ff == JOB_EX1D);
      op.own_addr  = fld_addr_of(job_ff, SLOT_OWN, i_ff, j_ff, k_ff);
      rd_fld_addr  = fld_addr_of(job_ff, slot_ff, i_ff, j_ff, k_ff);
      rd_coef_addr = {coef_sel_of(job_ff, slot_ff), i_ff, j_ff, k_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      slot_in  = slot_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      done     = 1'b0;
      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               if (nx == yfu_axis_type'(1) && ny == yfu_axis_type'(1)) begin
                  job_in = JOB_EX1D;
               end else if (nz == yfu_axis_type'(1)) begin
                  job_in = JOB_EZ;
               end else begin
                  job_in = JOB_EX;
               end
               state_in = SQ_LOAD;
            end
         end
         SQ_LOAD: begin
            i_in    = lo_i;
            j_in    = lo_j;
            k_in    = lo_k;
            slot_in = SLOT_OWN;
            if (!empty) begin
               state_in = SQ_RUN;
            end else if (to_drain) begin
               state_in = SQ_DRAIN;
            end else begin
               job_in = job_nxt;
            end
         end
         SQ_RUN: begin
            if (slot_ff == SLOT_B2) begin
               slot_in = SLOT_OWN;
               k_in    = k_last ? lo_k : k_nxt[AXIS_W-1:0];
               if (k_last) begin
                  j_in = j_last ? lo_j : j_nxt[AXIS_W-1:0];
               end
               if (k_last && j_last) begin
                  i_in = i_nxt[AXIS_W-1:0];
               end
               if (k_last && j_last && i_last) begin
                  if (to_drain) begin
                     state_in = SQ_DRAIN;
                  end else begin
                     job_in   = job_nxt;
                     state_in = SQ_LOAD;
                  end
               end
            end else begin
               slot_in = yfu_slot_type'(slot_ff + 3'd1);
            end
         end
         SQ_DRAIN: begin
            // e must be written back before h reads it
            if (!dp_busy) begin
               if (job_ff == JOB_HZ) begin
                  done     = 1'b1;
                  state_in = SQ_IDLE;
               end else begin
                  job_in   = JOB_HX;
                  state_in = SQ_LOAD;
               end
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      slot_ff <= slot_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
   end

endmodule

// ----- sv/yfu_dpath.sv -----
// update datapath: operand collect, differences, products, sum, write back
module yfu_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  yfu_pkg::yfu_op_type  op,
   input  yfu_pkg::yfu_val_type fld_data,
   input  yfu_pkg::yfu_val_type coef_data,
   input  logic                 clear_sat,
   output yfu_pkg::yfu_wr_type  wr,
   output logic                 busy,
   output logic                 sat
);
   import yfu_pkg::*;

   yfu_op_type  op_ff;
   yfu_val_type own_ff, a1_ff, b1_ff, a2_ff, c0_ff, c1_ff, c2_ff;

   logic                    s1_v_ff, s2_v_ff, s3_v_ff;
   logic [FLD_AW-1:0]       s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic                    s1_sat_ff, s2_sat_ff, s3_sat_ff;
   yfu_val_type             s1_own_ff, s1_c0_ff, s1_c1_ff, s1_c2_ff, s1_d1_ff, s1_d2_ff;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   yfu_val_type             t0_ff, t1_ff, t2_ff;
   yfu_wr_type              wr_ff;
   logic                    sat_ff;

   yfu_sat_type d1, d2, q0, q1, q2, sum;
   logic        launch;

   // differences, saturated per term
   always_comb begin
      launch = op_ff.valid && (op_ff.slot == SLOT_B2);
      d1 = clamp_val(PROD_W'(a1_ff) - PROD_W'(b1_ff));
      if (op_ff.single) begin
         d2.value = '0;
         d2.hit   = 1'b0;
      end else begin
         d2 = clamp_val(PROD_W'(a2_ff) - PROD_W'(fld_data));
      end
   end

   // floor-shifted products and the saturated sum
   always_comb begin
      q0  = clamp_val(p0_ff >>> FRAC_BITS);
      q1  = clamp_val(p1_ff >>> FRAC_BITS);
      q2  = clamp_val(p2_ff >>> FRAC_BITS);
      sum = clamp_val(PROD_W'(t0_ff) + PROD_W'(t1_ff) + PROD_W'(t2_ff));
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.valid <= 1'b0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         wr_ff.valid <= 1'b0;
         sat_ff      <= 1'b0;
      end else begin
         op_ff.valid <= op.valid;
         s1_v_ff     <= launch;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         wr_ff.valid <= s3_v_ff;
         if (clear_sat) begin
            sat_ff <= 1'b0;
         end else if (s3_v_ff && (s3_sat_ff || sum.hit)) begin
            sat_ff <= 1'b1;
         end
      end
   end

   // operand capture and payload stages
   always_ff @(posedge clock) begin
      op_ff.slot     <= op.slot;
      op_ff.single   <= op.single;
      op_ff.own_addr <= op.own_addr;
      if (op_ff.valid) begin
         case (op_ff.slot)
            SLOT_OWN: begin own_ff <= fld_data; c0_ff <= coef_data; end
            SLOT_A1:  begin a1_ff  <= fld_data; c1_ff <= coef_data; end
            SLOT_B1:  begin b1_ff  <= fld_data; c2_ff <= coef_data; end
            SLOT_A2:  a2_ff <= fld_data;
            default:  ;
         endcase
      end
      s1_own_ff  <= own_ff;
      s1_c0_ff   <= c0_ff;
      s1_c1_ff   <= c1_ff;
      s1_c2_ff   <= c2_ff;
      s1_d1_ff   <= d1.value;
      s1_d2_ff   <= d2.value;
      s1_sat_ff  <= d1.hit || d2.hit;
      s1_addr_ff <= op_ff.own_addr;
      p0_ff      <= PROD_W'(s1_c0_ff) * PROD_W'(s1_own_ff);
      p1_ff      <= PROD_W'(s1_c1_ff) * PROD_W'(s1_d1_ff);
      p2_ff      <= PROD_W'(s1_c2_ff) * PROD_W'(s1_d2_ff);
      s2_sat_ff  <= s1_sat_ff;
      s2_addr_ff <= s1_addr_ff;
      t0_ff      <= q0.value;
      t1_ff      <= q1.value;
      t2_ff      <= q2.value;
      s3_sat_ff  <= s2_sat_ff || q0.hit || q1.hit || q2.hit;
      s3_addr_ff <= s2_addr_ff;
      wr_ff.addr <= s3_addr_ff;
      wr_ff.data <= sum.value;
   end

   assign wr   = wr_ff;
   assign sat  = sat_ff;
   assign busy = op_ff.valid || s1_v_ff || s2_v_ff || s3_v_ff || wr_ff.valid;

endmodule

// ----- sv/yee_fdtd_field_update_top.sv -----
// top level of the yee grid field update engine
// write, no-op and coefficient-read transactions: result registered, valid in the cycle after accept
// field read: accept enters the read state, whose registered ram read data fills the response register
// time step: five operand reads per cell update on the one field ram read port, over a full 15x15x15
//   grid by default, plus a pipeline drain after e and after h
// reset: a clear pass zeroes all 24576 field ram words, no requests accepted until it ends
`include "assert_macros.svh"

module yee_fdtd_field_update_top (
   input logic      clock,
   input logic      reset,
   yfu_req_if.sink   req_ch,
   yfu_rsp_if.source rsp_ch,
   yfu_csr_if.sink   csr_ch
);
   import yfu_pkg::*;

   yfu_state_type     state_ff, state_in;
   logic [FLD_AW-1:0] clr_ff, clr_in;
   yfu_axis_type      nx_ff, ny_ff, nz_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   yfu_val_type rsp_value_ff, rsp_value_in;
   logic        rsp_done_ff, rsp_done_in;
   logic        rsp_sat_ff, rsp_sat_in;

   logic req_ready, accept, is_field, is_coef, start;

   logic               fw_en;
   logic [FLD_AW-1:0]  fw_addr, fr_addr, req_fld_addr;
   yfu_val_type        fw_data, fld_rd;
   logic               cw_en;
   logic [COEF_AW-1:0] cw_addr;
   yfu_val_type        coef_rd;

   yfu_op_type         seq_op;
   logic [FLD_AW-1:0]  seq_fld_addr;
   logic [COEF_AW-1:0] seq_coef_addr;
   logic               seq_done, dp_busy, dp_sat;
   yfu_wr_type         dp_wr;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= yfu_axis_type'(15);
         ny_ff <= yfu_axis_type'(15);
         nz_ff <= yfu_axis_type'(15);
      end else if (csr_ch.valid) begin
         unique case (yfu_csr_idx_type'(csr_ch.index))
            CSR_NX:  nx_ff <= csr_ch.data;
            CSR_NY:  ny_ff <= csr_ch.data;
            CSR_NZ:  nz_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // request decode
   always_comb begin
      req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
      accept       = req_ch.valid && req_ready;
      is_field     = req_ch.array_select < SEL_W'(NUM_FIELDS);
      is_coef      = !is_field && (req_ch.array_select < SEL_W'(NUM_SELECTS));
      req_fld_addr = {req_ch.array_select[COMP_W-1:0], req_ch.cell_x, req_ch.cell_y,
                      req_ch.cell_z};
   end

   assign req_ch.ready = req_ready;

   // control fsm and response register
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      start        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_sat_in   = rsp_sat_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + FLD_AW'(1);
            if (clr_ff == FLD_AW'(FLD_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_done_in  = 1'b0;
               rsp_sat_in   = 1'b0;
               unique case (yfu_req_code_type'(req_ch.req_type))
                  REQ_READ: begin
                     if (is_field) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  REQ_STEP: begin
                     start    = 1'b1;
                     state_in = ST_STEP;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = fld_rd;
            state_in     = ST_IDLE;
         end
         ST_STEP: begin
            if (seq_done) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = 1'b1;
               rsp_sat_in   = dp_sat;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.step_done  = rsp_done_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;

   // field ram ports
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         fw_en   = 1'b1;
         fw_addr = clr_ff;
         fw_data = '0;
      end else if (dp_wr.valid) begin
         fw_en   = 1'b1;
         fw_addr = dp_wr.addr;
         fw_data = dp_wr.data;
      end else begin
         fw_en   = accept && (req_ch.req_type == REQ_WRITE) && is_field;
         fw_addr = req_fld_addr;
         fw_data = req_ch.write_value;
      end
      fr_addr = (state_ff == ST_STEP) ? seq_fld_addr : req_fld_addr;
      cw_en   = accept && (req_ch.req_type == REQ_WRITE) && is_coef;
      cw_addr = {req_ch.array_select - SEL_W'(NUM_FIELDS), req_ch.cell_x, req_ch.cell_y,
                 req_ch.cell_z};
   end

   yfu_ram #(.WIDTH(VAL_W), .DEPTH(FLD_DEPTH)) u_fld_ram (
      .clock   (clock),
      .wr_en   (fw_en),
      .wr_addr (fw_addr),
      .wr_data (fw_data),
      .rd_addr (fr_addr),
      .rd_data (fld_rd)
   );

   yfu_ram #(.WIDTH(VAL_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (cw_addr),
      .wr_data (req_ch.write_value),
      .rd_addr (seq_coef_addr),
      .rd_data (coef_rd)
   );

   yfu_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .nx           (nx_ff),
      .ny           (ny_ff),
      .nz           (nz_ff),
      .dp_busy      (dp_busy),
      .op           (seq_op),
      .rd_fld_addr  (seq_fld_addr),
      .rd_coef_addr (seq_coef_addr),
      .done         (seq_done)
   );

   yfu_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .op        (seq_op),
      .fld_data  (fld_rd),
      .coef_data (coef_rd),
      .clear_sat (start),
      .wr        (dp_wr),
      .busy      (dp_busy),
      .sat       (dp_sat)
   );

   // checks
   `YFU_ASSERT(a_dp_wr_in_step, clock, reset, dp_wr.valid |-> state_ff == ST_STEP, "datapath write outside a time step")
   `YFU_ASSERT(a_done_drained, clock, reset, seq_done |-> !dp_busy, "step finished with updates in flight")
   `YFU_ASSERT(a_read_slot_free, clock, reset, state_ff == ST_READ |-> !rsp_valid_ff, "read data would overwrite a pending response")
   `YFU_ASSERT(a_sat_only_step, clock, reset, (rsp_valid_ff && !rsp_done_ff) |-> !rsp_sat_ff, "saturation flag on a non-step response")

endmodule
